// ===== sv/tsp_pkg.sv =====
package tsp_pkg;

    // Field and register widths
    localparam int TSP_DAC_BITS = 12;
    localparam int LEVEL_W      = 12;
    localparam int RAMP_W       = 8;
    localparam int HOLD_W       = 10;
    localparam int SPEED_W      = 12;
    localparam int AMP_W        = 16;
    localparam int TICK_W       = 10;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 12;

    // Shared multiplier and divider sizes
    localparam int MUL_A_W   = 16;
    localparam int MUL_B_W   = 12;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int QUOT_W    = PROD_W;
    localparam int DVSR_W    = 12;
    localparam int DIV_STEPS = QUOT_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Full-scale speed and full-scale DAC code
    localparam logic [SPEED_W-1:0] SPEED_FULL = 12'd2200;
    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 12'd4095;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_TICK  = 2'd1,
        OP_STOP  = 2'd2,
        OP_SLOW  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_UP    = 3'd1,
        PH_CONST = 3'd2,
        PH_DOWN  = 3'd3,
        PH_SLOW  = 3'd4
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_LEVEL     = 3'd0,
        CFG_RAMP_TICKS     = 3'd1,
        CFG_HOLD_TICKS     = 3'd2,
        CFG_STANDARD_SPEED = 3'd3,
        CFG_SLOW_LEVEL     = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MUL  = 2'd1,
        ST_DIV  = 2'd2,
        ST_FIN  = 2'd3
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic load_mul;
        logic div_step;
        logic commit;
    } tsp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_math;
        logic div_last;
        logic out_free;
    } tsp_sts_t;

endpackage

// ===== sv/tsp_div.sv =====
module tsp_div
    import tsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              step,
    input  logic [QUOT_W-1:0] dividend,
    input  logic [DVSR_W-1:0] divisor,
    output logic [QUOT_W-1:0] quot,
    output logic              rem_nz,
    output logic              last
);

    logic [QUOT_W-1:0]    quot_reg, quot_next;
    logic [DVSR_W-1:0]    rem_reg, rem_next;
    logic [DVSR_W-1:0]    dvsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    logic [DVSR_W:0] trial1, trial2;
    logic [DVSR_W:0] part1, part2;
    logic            ge1, ge2;

    // Two restoring steps per cycle, dividend bits shift out at the top
    always_comb
    begin
        trial1 = {rem_reg, quot_reg[QUOT_W-1]};
        ge1    = trial1 >= {1'b0, dvsr_reg};
        part1  = ge1 ? trial1 - {1'b0, dvsr_reg} : trial1;
        trial2 = {part1[DVSR_W-1:0], quot_reg[QUOT_W-2]};
        ge2    = trial2 >= {1'b0, dvsr_reg};
        part2  = ge2 ? trial2 - {1'b0, dvsr_reg} : trial2;

        quot_next = {quot_reg[QUOT_W-3:0], ge1, ge2};
        rem_next  = part2[DVSR_W-1:0];
        cnt_next  = cnt_reg - DIV_CNT_W'(1);
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= DIV_CNT_W'(DIV_STEPS);
        end
        else if (step)
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvsr_reg <= divisor;
        end
        else if (step)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign quot   = quot_reg;
    assign rem_nz = |rem_reg;
    assign last   = cnt_reg == DIV_CNT_W'(1);

endmodule

// ===== sv/tsp_dp.sv =====
module tsp_dp
    import tsp_pkg::*;
#(
    parameter int DAC_BITS = TSP_DAC_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tsp_cmd_t              cmd,
    output tsp_sts_t              sts,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [1:0]            operation,
    input  logic [SPEED_W-1:0]    speed,
    input  logic                  direction,
    input  logic                  standard_mode,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DAC_BITS-1:0]   dac_value,
    output logic                  motor_on,
    output logic [2:0]            phase,
    output logic                  profile_done
);

    localparam int PT_W = QUOT_W + 1;
    localparam logic [PT_W-1:0] DacMax = PT_W'((64'd1 << DAC_BITS) - 64'd1);

    // Configuration registers
    logic [LEVEL_W-1:0] zero_level_reg;
    logic [RAMP_W-1:0]  ramp_ticks_reg;
    logic [HOLD_W-1:0]  hold_ticks_reg;
    logic [SPEED_W-1:0] std_speed_reg;
    logic [LEVEL_W-1:0] slow_level_reg;

    // Profile state
    phase_t             phase_reg, phase_next;
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic [AMP_W-1:0]   amp_reg, amp_next;
    logic               dir_reg, dir_next;
    logic               motor_reg, motor_next;

    // Latched item
    op_t                op_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic               dir_in_reg;
    logic               std_reg;
    logic               sticky_reg;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic [DAC_BITS-1:0] dac_reg, dac_next;
    logic                motor_out_reg;
    phase_t              phase_out_reg;
    logic                done_reg, done_next;

    logic [RAMP_W-1:0]   r_eff;
    logic [TICK_W-1:0]   k_val;
    logic                start_right;
    logic [SPEED_W-1:0]  start_speed;
    logic [LEVEL_W-1:0]  start_lev;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [PROD_W-1:0]   product;
    logic [QUOT_W-1:0]   dividend;
    logic [DVSR_W-1:0]   divisor;
    logic [QUOT_W-1:0]   quot;
    logic                rem_nz;
    logic                div_last;
    logic [PT_W-1:0]     left_sum;
    logic [PT_W-1:0]     right_ceil;
    logic [LEVEL_W-1:0]  right_diff;
    logic [DAC_BITS-1:0] point_dac;
    logic [TICK_W:0]     tick_inc;
    op_t                 op_in;

    assign r_eff = (ramp_ticks_reg == '0) ? RAMP_W'(1) : ramp_ticks_reg;
    assign op_in = op_t'(operation);

    // Profile fraction numerator for the current phase
    always_comb
    begin
        unique case (phase_reg)
            PH_UP:    k_val = tick_reg;
            PH_CONST: k_val = TICK_W'(r_eff);
            PH_DOWN:  k_val = (tick_reg < TICK_W'(r_eff)) ? TICK_W'(r_eff) - tick_reg : '0;
            default:  k_val = '0;
        endcase
    end

    // Operand selection for the shared multiplier
    always_comb
    begin
        start_right = std_reg | dir_in_reg;
        start_speed = std_reg ? std_speed_reg : speed_reg;
        start_lev   = start_right ? zero_level_reg : LEVEL_FULL - zero_level_reg;
        if (op_reg == OP_START)
        begin
            mul_a    = MUL_A_W'(start_speed);
            mul_b    = start_lev;
        end
        else
        begin
            mul_a    = amp_reg;
            mul_b    = MUL_B_W'(k_val);
        end
    end

    assign product = mul_a * mul_b;

    // Start: speed*level*16 / 2200; tick: (amp*k >> 4) / ramp, low bits kept as sticky
    always_comb
    begin
        if (op_reg == OP_START)
        begin
            dividend = {product[PROD_W-5:0], 4'b0000};
            divisor  = SPEED_FULL;
        end
        else
        begin
            dividend = {4'b0000, product[PROD_W-1:4]};
            divisor  = DVSR_W'(r_eff);
        end
    end

    tsp_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cmd.load_mul),
        .step     (cmd.div_step),
        .dividend (dividend),
        .divisor  (divisor),
        .quot     (quot),
        .rem_nz   (rem_nz),
        .last     (div_last)
    );

    // Profile point: floor for leftward, ceiling subtracted for rightward, then clamp
    always_comb
    begin
        left_sum   = PT_W'(zero_level_reg) + PT_W'(quot);
        right_ceil = PT_W'(quot) + PT_W'(rem_nz | sticky_reg);
        right_diff = zero_level_reg - right_ceil[LEVEL_W-1:0];
        if (!dir_reg)
        begin
            point_dac = (left_sum > DacMax) ? DacMax[DAC_BITS-1:0] : left_sum[DAC_BITS-1:0];
        end
        else if (right_ceil >= PT_W'(zero_level_reg))
        begin
            point_dac = '0;
        end
        else
        begin
            point_dac = (PT_W'(right_diff) > DacMax) ? DacMax[DAC_BITS-1:0]
                                                     : DAC_BITS'(right_diff);
        end
    end

    // Next profile state and result for the latched item
    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        amp_next   = amp_reg;
        dir_next   = dir_reg;
        motor_next = motor_reg;
        dac_next   = DAC_BITS'(zero_level_reg);
        done_next  = 1'b0;
        tick_inc   = {1'b0, tick_reg} + (TICK_W+1)'(1);

        unique case (op_reg)
            OP_START:
            begin
                dir_next   = start_right;
                amp_next   = (|quot[QUOT_W-1:AMP_W]) ? '1 : quot[AMP_W-1:0];
                motor_next = 1'b1;
                phase_next = PH_UP;
                tick_next  = '0;
            end
            OP_STOP:
            begin
                motor_next = 1'b0;
                phase_next = PH_IDLE;
                tick_next  = '0;
            end
            OP_SLOW:
            begin
                dac_next   = DAC_BITS'(slow_level_reg);
                motor_next = 1'b1;
                phase_next = PH_SLOW;
                tick_next  = '0;
            end
            default:
            begin
                unique case (phase_reg)
                    PH_UP:
                    begin
                        dac_next  = point_dac;
                        tick_next = tick_inc[TICK_W-1:0];
                        if (tick_inc >= (TICK_W+1)'(r_eff))
                        begin
                            tick_next  = '0;
                            phase_next = (hold_ticks_reg == '0) ? PH_DOWN : PH_CONST;
                        end
                    end
                    PH_CONST:
                    begin
                        dac_next  = point_dac;
                        tick_next = tick_inc[TICK_W-1:0];
                        if (tick_inc >= (TICK_W+1)'(hold_ticks_reg))
                        begin
                            tick_next  = '0;
                            phase_next = PH_DOWN;
                        end
                    end
                    PH_DOWN:
                    begin
                        dac_next  = point_dac;
                        tick_next = tick_inc[TICK_W-1:0];
                        if (tick_inc >= (TICK_W+1)'(r_eff))
                        begin
                            tick_next  = '0;
                            phase_next = PH_IDLE;
                            motor_next = 1'b0;
                            done_next  = 1'b1;
                        end
                    end
                    PH_SLOW:
                    begin
                        dac_next = DAC_BITS'(slow_level_reg);
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_level_reg <= 12'd2610;
            ramp_ticks_reg <= 8'd20;
            hold_ticks_reg <= 10'd120;
            std_speed_reg  <= 12'd1800;
            slow_level_reg <= 12'd2372;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ZERO_LEVEL:     zero_level_reg <= cfg_data[LEVEL_W-1:0];
                CFG_RAMP_TICKS:     ramp_ticks_reg <= cfg_data[RAMP_W-1:0];
                CFG_HOLD_TICKS:     hold_ticks_reg <= cfg_data[HOLD_W-1:0];
                CFG_STANDARD_SPEED: std_speed_reg  <= cfg_data[SPEED_W-1:0];
                CFG_SLOW_LEVEL:     slow_level_reg <= cfg_data[LEVEL_W-1:0];
                default:            ;
            endcase
        end
    end

    // Profile state, updated when the result is committed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            amp_reg   <= '0;
            dir_reg   <= 1'b0;
            motor_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            amp_reg   <= amp_next;
            dir_reg   <= dir_next;
            motor_reg <= motor_next;
        end
    end

    // Item capture and sticky bit of the tick product
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg     <= op_in;
            speed_reg  <= speed;
            dir_in_reg <= direction;
            std_reg    <= standard_mode;
        end
        if (cmd.load_mul)
        begin
            sticky_reg <= |product[3:0];
        end
    end

    // Output register
    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            dac_reg       <= dac_next;
            motor_out_reg <= motor_next;
            phase_out_reg <= phase_next;
            done_reg      <= done_next;
        end
    end

    // Status back to the controller
    assign sts.need_math = (op_in == OP_START) ||
                           ((op_in == OP_TICK) &&
                            (phase_reg == PH_UP || phase_reg == PH_CONST ||
                             phase_reg == PH_DOWN));
    assign sts.div_last  = div_last;
    assign sts.out_free  = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign dac_value    = dac_reg;
    assign motor_on     = motor_out_reg;
    assign phase        = phase_out_reg;
    assign profile_done = done_reg;

    // A finished profile always leaves the motor off and the phase idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> phase_out_reg == PH_IDLE && !motor_out_reg)
        else $error("profile end without idle and motor off");

    // Any active phase drives the motor
    a_active_motor: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_IDLE |-> motor_reg)
        else $error("active phase with motor disabled");

    // No result is committed over one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !out_valid_reg || !out_stall)
        else $error("result overwritten while stalled");

endmodule

// ===== sv/tsp_ctrl.sv =====
module tsp_ctrl
    import tsp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  tsp_sts_t sts,
    output tsp_cmd_t cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencing: accept, multiply, divide, commit
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = sts.need_math ? ST_MUL : ST_FIN;
                end
            end
            ST_MUL:
            begin
                cmd.load_mul = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // An accepted item always moves on to arithmetic or straight to commit
    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE && in_valid |=> state_reg == ST_MUL || state_reg == ST_FIN)
        else $error("accepted transfer not processed");

    // The multiply cycle is always followed by the divider
    a_mul_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |=> state_reg == ST_DIV)
        else $error("multiply not followed by divide");

    // Leaving the divider only on its last step
    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV && !sts.div_last |=> state_reg == ST_DIV)
        else $error("divider left early");

endmodule

// ===== sv/trapezoid_speed_profile_top.sv =====
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+----------------------------------------
// in       | input     | in_valid / in_stall | operation, speed, direction, standard_mode
// out      | output    | out_valid/out_stall | dac_value, motor_on, phase, profile_done
// cfg      | input     | cfg_we              | cfg_index, cfg_data
//
// Start and running-profile ticks pass through accept, one multiply, 14 divider steps
// (two quotient bits a cycle in the shared restoring divider) and commit.
// Stop, slow and ticks while idle or slow go straight from accept to commit.
// Reset (rst_n low, asynchronous) restores the register defaults, idle phase, motor off.
// in_stall is high while an item is in progress; the result sits in an output register,
// so the next item is taken while out_stall holds the previous result.
module trapezoid_speed_profile_top
    import tsp_pkg::*;
#(
    parameter int DAC_BITS = TSP_DAC_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            operation,
    input  logic [SPEED_W-1:0]    speed,
    input  logic                  direction,
    input  logic                  standard_mode,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DAC_BITS-1:0]   dac_value,
    output logic                  motor_on,
    output logic [2:0]            phase,
    output logic                  profile_done
);

    tsp_cmd_t cmd;
    tsp_sts_t sts;

    tsp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    tsp_dp #(
        .DAC_BITS (DAC_BITS)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .operation     (operation),
        .speed         (speed),
        .direction     (direction),
        .standard_mode (standard_mode),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .dac_value     (dac_value),
        .motor_on      (motor_on),
        .phase         (phase),
        .profile_done  (profile_done)
    );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import tsp_pkg::*;

    // Results of one transfer on the output channel
    typedef struct packed {
        logic [TSP_DAC_BITS-1:0] dac;
        logic                    motor;
        phase_t                  ph;
        logic                    done;
    } point_t;

    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_CFG  = 1'b1
    } row_kind_t;

    // One line of the directed table: either an item or a register write
    typedef struct packed {
        row_kind_t            kind;
        op_t                  op;
        logic [SPEED_W-1:0]   spd;
        logic                 dir;
        logic                 std_mode;
        cfg_idx_t             reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic                 has_want;
        point_t               want;
    } row_t;

    localparam point_t NO_WANT = '{12'd0, 1'b0, PH_IDLE, 1'b0};
    localparam int     N_ROWS  = 35;
    localparam int     RANDOM_ITEMS = 700;
    localparam int     TICK_CAP = 60;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] operation = '0;
    logic [SPEED_W-1:0] speed = '0;
    logic direction = 1'b0;
    logic standard_mode = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [TSP_DAC_BITS-1:0] dac_value;
    logic motor_on;
    logic [2:0] phase;
    logic profile_done;

    // Register copies held by the predictor
    logic [LEVEL_W-1:0] zero_lvl = 12'd2610;
    logic [RAMP_W-1:0]  ramp_len = 8'd20;
    logic [HOLD_W-1:0]  hold_len = 10'd120;
    logic [SPEED_W-1:0] std_speed = 12'd1800;
    logic [LEVEL_W-1:0] slow_lvl = 12'd2372;

    // Profile state held by the predictor
    phase_t      prof_phase = PH_IDLE;
    int unsigned prof_tick = 0;
    int unsigned prof_amp = 0;
    logic        prof_right = 1'b0;
    logic        prof_motor = 1'b0;

    point_t pending_points[$];
    int     mismatch_count = 0;
    int     results_got = 0;
    int     items_sent = 0;
    int     burst_left = 0;

    trapezoid_speed_profile_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .speed         (speed),
        .direction     (direction),
        .standard_mode (standard_mode),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .dac_value     (dac_value),
        .motor_on      (motor_on),
        .phase         (phase),
        .profile_done  (profile_done)
    );

    always #4 clk = ~clk;

    function automatic int unsigned ramp_eff();
        return (ramp_len == 0) ? 1 : int'(ramp_len);
    endfunction

    // Q12.4 amplitude latched on a start
    function automatic int unsigned amplitude_for(logic [SPEED_W-1:0] spd, logic right);
        longint lev;
        longint a;
        lev = right ? longint'(zero_lvl) : 64'd4095 - longint'(zero_lvl);
        a = (longint'(spd) * lev * 16) / 2200;
        return (a > 65535) ? 65535 : int'(a);
    endfunction

    // DAC code at fraction k/R of the amplitude, floored and clipped
    function automatic logic [TSP_DAC_BITS-1:0] profile_point(int unsigned k);
        longint r;
        longint base;
        longint offs;
        longint v;
        longint q;
        r = longint'(ramp_eff());
        base = longint'(zero_lvl) * 16 * r;
        offs = longint'(prof_amp) * longint'(k);
        v = prof_right ? base - offs : base + offs;
        if (v <= 0)
            return '0;
        q = v / (16 * r);
        if (q > 4095)
            return 12'd4095;
        return q[TSP_DAC_BITS-1:0];
    endfunction

    // Advance the profile by one item and return the point it produces
    function automatic point_t profile_step(op_t op, logic [SPEED_W-1:0] spd, logic dir,
                                            logic std_mode);
        point_t res;
        int unsigned r;
        r = ramp_eff();
        res.dac = zero_lvl;
        res.done = 1'b0;
        case (op)
            OP_START:
            begin
                if (std_mode)
                begin
                    prof_right = 1'b1;
                    prof_amp = amplitude_for(std_speed, 1'b1);
                end
                else
                begin
                    prof_right = dir;
                    prof_amp = amplitude_for(spd, dir);
                end
                prof_motor = 1'b1;
                prof_phase = PH_UP;
                prof_tick = 0;
            end
            OP_STOP:
            begin
                prof_motor = 1'b0;
                prof_phase = PH_IDLE;
                prof_tick = 0;
            end
            OP_SLOW:
            begin
                res.dac = slow_lvl;
                prof_motor = 1'b1;
                prof_phase = PH_SLOW;
                prof_tick = 0;
            end
            default:
            begin
                case (prof_phase)
                    PH_UP:
                    begin
                        res.dac = profile_point(prof_tick);
                        prof_tick++;
                        if (prof_tick >= r)
                        begin
                            prof_tick = 0;
                            prof_phase = (hold_len == 0) ? PH_DOWN : PH_CONST;
                        end
                    end
                    PH_CONST:
                    begin
                        res.dac = profile_point(r);
                        prof_tick++;
                        if (prof_tick >= hold_len)
                        begin
                            prof_tick = 0;
                            prof_phase = PH_DOWN;
                        end
                    end
                    PH_DOWN:
                    begin
                        res.dac = profile_point((prof_tick < r) ? r - prof_tick : 0);
                        prof_tick++;
                        if (prof_tick >= r)
                        begin
                            prof_tick = 0;
                            prof_phase = PH_IDLE;
                            prof_motor = 1'b0;
                            res.done = 1'b1;
                        end
                    end
                    PH_SLOW:
                        res.dac = slow_lvl;
                    default:
                        prof_phase = PH_IDLE;
                endcase
            end
        endcase
        res.motor = prof_motor;
        res.ph = prof_phase;
        return res;
    endfunction

    // Offer one item, in bursts with gaps between them, and log its expected point
    task automatic send_item(op_t op, logic [SPEED_W-1:0] spd, logic dir, logic std_mode,
                             logic has_want, point_t want);
        point_t pred;
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 10);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        operation <= op;
        speed <= spd;
        direction <= dir;
        standard_mode <= std_mode;
        do
            @(posedge clk);
        while (in_stall);
        pred = profile_step(op, spd, dir, std_mode);
        pending_points.push_back(has_want ? want : pred);
        items_sent++;
        burst_left--;
    endtask

    task automatic send_op(op_t op, logic [SPEED_W-1:0] spd, logic dir, logic std_mode);
        send_item(op, spd, dir, std_mode, 1'b0, NO_WANT);
    endtask

    // Sender goes quiet until every outstanding point has been returned
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_points.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        wait_drained();
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ZERO_LEVEL:     zero_lvl = val[LEVEL_W-1:0];
            CFG_RAMP_TICKS:     ramp_len = val[RAMP_W-1:0];
            CFG_HOLD_TICKS:     hold_len = val[HOLD_W-1:0];
            CFG_STANDARD_SPEED: std_speed = val[SPEED_W-1:0];
            CFG_SLOW_LEVEL:     slow_lvl = val[LEVEL_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [SPEED_W-1:0] pick_speed();
        case ($urandom_range(0, 9))
            0: return 12'd0;
            1: return 12'd2200;
            2: return 12'd4095;
            3, 4: return SPEED_W'($urandom_range(0, 4095));
            default: return SPEED_W'($urandom_range(0, 2200));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_level();
        case ($urandom_range(0, 5))
            0: return 12'd0;
            1: return 12'd4095;
            default: return CFG_DATA_W'($urandom_range(0, 4095));
        endcase
    endfunction

    // Result checker: every transfer against the oldest expected point
    always @(posedge clk)
    begin : point_check
        point_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_got++;
            if (pending_points.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transfer: dac %0d motor %0b phase %0d done %0b",
                             dac_value, motor_on, phase, profile_done);
            end
            else
            begin
                want = pending_points.pop_front();
                if (dac_value !== want.dac || motor_on !== want.motor ||
                    phase !== want.ph || profile_done !== want.done)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("point %0d: expected dac %0d motor %0b phase %0d done %0b, %s",
                                 results_got, want.dac, want.motor, want.ph, want.done,
                                 $sformatf("got dac %0d motor %0b phase %0d done %0b",
                                           dac_value, motor_on, phase, profile_done));
                end
            end
        end
    end

    // Receiver stall pattern, with one long hold-off once traffic is flowing
    initial
    begin : receiver
        int seg_mode;
        int seg_len;
        bit long_hold_done;
        long_hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!long_hold_done && results_got >= 150)
            begin
                long_hold_done = 1'b1;
                seg_mode = 3;
                seg_len = 400;
            end
            else
            begin
                seg_mode = $urandom_range(0, 2);
                seg_len = $urandom_range(10, 80);
            end
            repeat (seg_len)
            begin
                @(negedge clk);
                case (seg_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 2) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= 1'b1;
                endcase
            end
        end
    end

    initial
    begin : watchdog
        #5000000;
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        row_t directed [N_ROWS];
        int budget;
        int phase_start;
        int run_len;
        int pick;

        directed = '{
            // after reset: idle tick, stop, slow and tick while slow
            '{ROW_ITEM, OP_TICK, 12'd0, 1'b0, 1'b0, CFG_ZERO_LEVEL, 12'd0, 1'b1,
              '{12'd2610, 1'b0, PH_IDLE, 1'b0}},
            '{ROW_ITEM, OP_STOP, 12'd4095, 1'b1, 1'b1, CFG_ZERO_LEVEL, 12'd0, 1'b1,
              '{12'd2610, 1'b0, PH_IDLE, 1'b0}},
            '{ROW_ITEM, OP_SLOW, 12'd0, 1'b0, 1'b0, CFG_ZERO_LEVEL, 12'd0, 1'b1,
              '{12'd2372, 1'b1, PH_SLOW, 1'b0}},
            '{ROW_ITEM, OP_TICK, 12'd0, 1'b0, 1'b0, CFG_ZERO_LEVEL, 12'd0, 1'b1,
              '{12'd2372, 1'b1, PH_SLOW, 1'b0}},
            // standard mode ignores speed and direction
            '{ROW_ITEM, OP_START, 12'd4095, 1'b0, 1'b1, CFG_ZERO_LEVEL, 12'd0, 1'b1,
              '{12'd2610, 1'b1, PH_UP, 1'b0}},
            '{ROW_ITEM, OP_TICK, 12'd0, 1'b0, 1'b0, CFG_ZERO_LEVEL, 12'd0, 1'b0, NO_WANT},
            '{ROW_ITEM, OP_TICK, 12'd0, 1'b0, 1'b0, CFG_ZERO_LEVEL, 12'd0, 1'b0, NO_WANT},
            // restart while running, zero speed
            '{ROW_ITEM, OP_START, 12'd0, 1'b0, 1'b0, CFG_ZERO_LEVEL, 12'd0, 1'b1,
              '{12'd2610, 1'b1, PH_UP, 1'b0}},
            '{ROW_ITEM, OP_TICK, 12'd0, 1'b0, 1'b0, CFG_ZERO_LEVEL, 12'd0, 1'b0, NO_WANT},
            // speed above full scale to the right saturates the amplitude
            '{ROW_ITEM, OP_START, 12'd4095, 1'b1, 1'b0, CFG_ZERO_LEVEL, 12'd0, 1'b1,
              '{12'd2610, 1'b1, PH_UP, 1'b0}},
            '{ROW_ITEM, OP_TICK, 12'd0, 1'b0, 1'b0, CFG_ZERO_LEVEL, 12'd0, 1'b0, NO_WANT},
            '{ROW_ITEM, OP_TICK, 12'd0, 1'b0, 1'b0, CFG_ZERO_LEVEL, 12'd0, 1'b0, NO_WANT},
            '{ROW_ITEM, OP_STOP, 12'd0, 1'b0, 1'b0, CFG_ZERO_LEVEL, 12'd0, 1'b1,
              '{12'd2610, 1'b0, PH_IDLE, 1'b0}},
            // zero ramp length behaves as one, zero hold skips the constant phase
            '{ROW_CFG, OP_TICK, 12'd0, 1'b0, 1'b0, CFG_RAMP_TICKS, 12'd0, 1'b0, NO_WANT},
            '{ROW_CFG, OP_TICK, 12'd0, 1'b0, 1'b0, CFG_HOLD_TICKS, 12'd0, 1'b0, NO_WANT},
            '{ROW_ITEM, OP_START, 12'd2200, 1'b1, 1'b0, CFG_ZERO_LEVEL, 12'd0, 1'b1,
              '{12'd2610, 1'b1, PH_UP, 1'b0}},
            '{ROW_ITEM, OP_TICK, 12'd0, 1'b0, 1'b0, CFG_ZERO_LEVEL, 12'd0, 1'b0, NO_WANT},
            '{ROW_ITEM, OP_TICK, 12'd0, 1'b0, 1'b0, CFG_ZERO_LEVEL, 12'd0, 1'b0, NO_WANT},
            // bottom zero level, full leftward profile to its end
            '{ROW_CFG, OP_TICK, 12'd0, 1'b0, 1'b0, CFG_ZERO_LEVEL, 12'd0, 1'b0, NO_WANT},
            '{ROW_CFG, OP_TICK, 12'd0, 1'b0, 1'b0, CFG_RAMP_TICKS, 12'd2, 1'b0, NO_WANT},
            '{ROW_CFG, OP_TICK, 12'd0, 1'b0, 1'b0, CFG_HOLD_TICKS, 12'd1, 1'b0, NO_WANT},
            '{ROW_ITEM, OP_START, 12'd2200, 1'b0, 1'b0, CFG_ZERO_LEVEL, 12'd0, 1'b1,
              '{12'd0, 1'b1, PH_UP, 1'b0}},
            '{ROW_ITEM, OP_TICK, 12'd0, 1'b0, 1'b0, CFG_ZERO_LEVEL, 12'd0, 1'b0, NO_WANT},
            '{ROW_ITEM, OP_TICK, 12'd0, 1'b0, 1'b0, CFG_ZERO_LEVEL, 12'd0, 1'b0, NO_WANT},
            '{ROW_ITEM, OP_TICK, 12'd0, 1'b0, 1'b0, CFG_ZERO_LEVEL, 12'd0, 1'b0, NO_WANT},
            '{ROW_ITEM, OP_TICK, 12'd0, 1'b0, 1'b0, CFG_ZERO_LEVEL, 12'd0, 1'b0, NO_WANT},
            '{ROW_ITEM, OP_TICK, 12'd0, 1'b0, 1'b0, CFG_ZERO_LEVEL, 12'd0, 1'b0, NO_WANT},
            // top zero level, full-scale standard speed to the right
            '{ROW_CFG, OP_TICK, 12'd0, 1'b0, 1'b0, CFG_ZERO_LEVEL, 12'd4095, 1'b0, NO_WANT},
            '{ROW_CFG, OP_TICK, 12'd0, 1'b0, 1'b0, CFG_STANDARD_SPEED, 12'd2200, 1'b0,
              NO_WANT},
            '{ROW_ITEM, OP_START, 12'd0, 1'b1, 1'b1, CFG_ZERO_LEVEL, 12'd0, 1'b1,
              '{12'd4095, 1'b1, PH_UP, 1'b0}},
            '{ROW_ITEM, OP_TICK, 12'd0, 1'b0, 1'b0, CFG_ZERO_LEVEL, 12'd0, 1'b0, NO_WANT},
            '{ROW_ITEM, OP_TICK, 12'd0, 1'b0, 1'b0, CFG_ZERO_LEVEL, 12'd0, 1'b0, NO_WANT},
            '{ROW_ITEM, OP_TICK, 12'd0, 1'b0, 1'b0, CFG_ZERO_LEVEL, 12'd0, 1'b0, NO_WANT},
            // slow level at full scale
            '{ROW_CFG, OP_TICK, 12'd0, 1'b0, 1'b0, CFG_SLOW_LEVEL, 12'd4095, 1'b0, NO_WANT},
            '{ROW_ITEM, OP_SLOW, 12'd0, 1'b0, 1'b0, CFG_ZERO_LEVEL, 12'd0, 1'b1,
              '{12'd4095, 1'b1, PH_SLOW, 1'b0}}
        };

        // Reset
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed table
        for (int i = 0; i < N_ROWS; i++)
        begin
            if (directed[i].kind == ROW_CFG)
                write_register(directed[i].reg_idx, directed[i].reg_val);
            else
                send_item(directed[i].op, directed[i].spd, directed[i].dir,
                          directed[i].std_mode, directed[i].has_want, directed[i].want);
        end

        // Random part: one register setting per stretch, mostly whole profiles
        phase_start = items_sent;
        while (items_sent - phase_start < RANDOM_ITEMS)
        begin
            write_register(CFG_ZERO_LEVEL, pick_level());
            case ($urandom_range(0, 9))
                0: write_register(CFG_RAMP_TICKS, 12'd0);
                1: write_register(CFG_RAMP_TICKS, 12'd255);
                2: write_register(CFG_RAMP_TICKS, 12'd1);
                default: write_register(CFG_RAMP_TICKS, CFG_DATA_W'($urandom_range(1, 8)));
            endcase
            case ($urandom_range(0, 9))
                0: write_register(CFG_HOLD_TICKS, 12'd0);
                1: write_register(CFG_HOLD_TICKS, 12'd1023);
                default: write_register(CFG_HOLD_TICKS, CFG_DATA_W'($urandom_range(0, 10)));
            endcase
            write_register(CFG_STANDARD_SPEED, pick_speed());
            write_register(CFG_SLOW_LEVEL, pick_level());

            budget = items_sent + $urandom_range(40, 90);
            while (items_sent < budget)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                begin
                    send_op(OP_START, pick_speed(), 1'($urandom), ($urandom_range(0, 3) == 0));
                    run_len = 2 * ramp_eff() + int'(hold_len);
                    if (run_len > TICK_CAP)
                        run_len = TICK_CAP;
                    run_len += $urandom_range(0, 2);
                    repeat (run_len)
                        send_op(OP_TICK, SPEED_W'($urandom), 1'($urandom), 1'($urandom));
                end
                else if (pick == 7)
                begin
                    send_op(OP_STOP, SPEED_W'($urandom), 1'($urandom), 1'($urandom));
                    send_op(OP_TICK, SPEED_W'($urandom), 1'($urandom), 1'($urandom));
                end
                else if (pick == 8)
                begin
                    send_op(OP_SLOW, SPEED_W'($urandom), 1'($urandom), 1'($urandom));
                    repeat ($urandom_range(1, 3))
                        send_op(OP_TICK, SPEED_W'($urandom), 1'($urandom), 1'($urandom));
                end
                else
                begin
                    // noise: any operation with any fields
                    repeat ($urandom_range(1, 4))
                        send_op(op_t'($urandom_range(0, 3)), pick_speed(), 1'($urandom),
                                1'($urandom));
                end
            end
        end

        // Let everything drain, then allow for stray transfers
        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && pending_points.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
